// ----- rtl/rcs_pkg.sv -----
`default_nettype none

package rcs_pkg;

    localparam int MAX_SAMPLES = 65536;

    localparam int SAMPLE_W = 32;
    localparam int NODATA_W = 24;
    localparam int FRAC_W   = 8;
    localparam int GREY_W   = 8;
    localparam int INDEX_W  = 16;

    // (v - min) is one bit wider than a sample, times 255 adds eight more
    localparam int DEN_W = SAMPLE_W + 1;
    localparam int NUM_W = DEN_W + 8;

    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_LOAD  = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic CFG_NODATA    = 1'b0;
    localparam logic CFG_AUTOSCALE = 1'b1;

    localparam logic signed [NODATA_W-1:0] NODATA_RST = -24'sd9999;
    localparam logic                       AUTOSCALE_RST = 1'b1;
    localparam logic signed [SAMPLE_W-1:0] MIN_START = 32'sh0100_0000;
    localparam logic signed [SAMPLE_W-1:0] MAX_START = 32'sh0000_0000;

    localparam logic [GREY_W-1:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [GREY_W-1:0] ALPHA_CLEAR  = 8'h00;

    typedef struct packed {
        logic [1:0]                  cmd;
        logic signed [SAMPLE_W-1:0]  sample;
        logic [INDEX_W-1:0]          pixel_index;
    } t_in_item;

    typedef struct packed {
        logic [GREY_W-1:0] grey;
        logic [GREY_W-1:0] alpha;
        logic              in_range;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SCALE,
        S_DIV,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

// ----- rtl/raster_contrast_stretch.sv -----
// min/max contrast stretch of a raster to grey. load beats store signed
// 24.8 samples in order into an on-chip sample memory (MAX_SAMPLES deep) and
// track a running min and max that skip the no-data marker; a start beat
// clears the count, min and max (the memory itself is never cleared, and
// reads never reach past the count). a read beat returns one pixel: with
// autoscale on, grey = floor((v-min)*255/(max-min)) low 8 bits, with it off
// the value truncated toward zero, low 8 bits; alpha 255 for a real sample,
// 0 for no-data or an index past the count. a read runs S_READ, S_OUT if the
// pixel is out of range, no-data or autoscale is off; S_READ, S_SCALE, S_OUT
// if the range is flat (grey 0); S_READ, S_SCALE, S_DIV, S_OUT if stretching,
// S_DIV waiting on the bit-serial divider, one quotient bit per cycle over a
// 41-bit numerator. one item is in flight at a time; a finished result sits
// in the output register while the next beat is taken
module raster_contrast_stretch #(
    parameter int MAX_SAMPLES = rcs_pkg::MAX_SAMPLES
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // input channel
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire rcs_pkg::t_in_item                 i_in_item,
    // output channel
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output rcs_pkg::t_out_item                     o_out_item,
    // configuration writes
    input  wire logic                              i_cfg_we,
    input  wire logic                              i_cfg_idx,
    input  wire logic [rcs_pkg::NODATA_W-1:0]      i_cfg_data
);

    localparam int AW  = $clog2(MAX_SAMPLES);
    localparam int CW  = $clog2(MAX_SAMPLES + 1);
    localparam int IW  = rcs_pkg::INDEX_W;
    localparam int XW  = (CW > IW) ? CW : IW;
    localparam int SW  = rcs_pkg::SAMPLE_W;
    localparam int DW  = rcs_pkg::DEN_W;
    localparam int NW  = rcs_pkg::NUM_W;
    localparam int GW  = rcs_pkg::GREY_W;
    localparam int FW  = rcs_pkg::FRAC_W;

    // configuration
    logic signed [rcs_pkg::NODATA_W-1:0] r_nodata;
    logic                                r_autoscale;

    // image state
    logic [CW-1:0]        r_count;
    logic signed [SW-1:0] r_min;
    logic signed [SW-1:0] r_max;

    // read pipeline
    rcs_pkg::t_state      r_state, n_state;
    logic                 r_inr;
    logic signed [DW-1:0] r_diff;
    logic signed [DW-1:0] r_range;
    rcs_pkg::t_out_item   r_res;

    // output register
    logic                 r_out_valid;
    rcs_pkg::t_out_item   r_out_item;

    // control decoded from state
    logic accept;
    logic load_ok;
    logic mem_we;
    logic mem_re;
    logic div_start;
    logic out_load;

    logic [XW-1:0]        idx_x;
    logic [AW-1:0]        raddr;
    logic                 idx_in;
    logic signed [SW-1:0] rdata;
    logic signed [SW-1:0] nodata_fx;
    logic                 smp_nd;
    logic                 rd_nd;
    logic                 stretch;
    logic [GW-1:0]        trunc_grey;
    logic signed [NW-1:0] scaled;
    logic                 div_done;
    logic [GW-1:0]        div_grey;

    // no-data marker in the sample's fixed-point format
    assign nodata_fx = {r_nodata, {FW{1'b0}}};

    assign accept  = i_in_valid && !o_in_stall;
    assign load_ok = (r_count < CW'(MAX_SAMPLES));
    assign smp_nd  = (i_in_item.sample == nodata_fx);

    // pixel index against the fill count, both widened to a common width
    assign idx_x  = XW'(i_in_item.pixel_index);
    assign raddr  = idx_x[AW-1:0];
    assign idx_in = (idx_x < XW'(r_count));

    rcs_store #(
        .DEPTH (MAX_SAMPLES),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_in_item.sample),
        .i_re    (mem_re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // stored sample is on the memory output in S_READ
    assign rd_nd   = (rdata == nodata_fx);
    assign stretch = r_inr && !rd_nd && r_autoscale;

    // truncation toward zero: floor, plus one when negative and inexact
    assign trunc_grey = rdata[FW+GW-1:FW]
                      + GW'(rdata[SW-1] && (rdata[FW-1:0] != '0));

    // (v - min) * 255 as (x << 8) - x
    assign scaled = $signed({r_diff, 8'h00}) - NW'(r_diff);

    rcs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (scaled),
        .i_den   (r_range),
        .o_done  (div_done),
        .o_grey  (div_grey)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rcs_pkg::S_IDLE: begin
                if (accept && i_in_item.cmd == rcs_pkg::CMD_READ) begin
                    n_state = rcs_pkg::S_READ;
                end
            end
            rcs_pkg::S_READ: begin
                n_state = stretch ? rcs_pkg::S_SCALE : rcs_pkg::S_OUT;
            end
            rcs_pkg::S_SCALE: begin
                n_state = (r_range == '0) ? rcs_pkg::S_OUT : rcs_pkg::S_DIV;
            end
            rcs_pkg::S_DIV: begin
                if (div_done) begin
                    n_state = rcs_pkg::S_OUT;
                end
            end
            rcs_pkg::S_OUT: begin
                if (out_load) begin
                    n_state = rcs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rcs_pkg::S_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb begin
        o_in_stall = (r_state != rcs_pkg::S_IDLE);
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        case (r_state)
            rcs_pkg::S_IDLE: begin
                mem_we = accept && i_in_item.cmd == rcs_pkg::CMD_LOAD && load_ok;
                mem_re = accept && i_in_item.cmd == rcs_pkg::CMD_READ;
            end
            rcs_pkg::S_SCALE: begin
                div_start = (r_range != '0);
            end
            rcs_pkg::S_OUT: begin
                // output register free, or its beat leaves this cycle
                out_load = !r_out_valid || !i_out_stall;
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rcs_pkg::S_IDLE;
            r_nodata    <= rcs_pkg::NODATA_RST;
            r_autoscale <= rcs_pkg::AUTOSCALE_RST;
            r_count     <= '0;
            r_min       <= rcs_pkg::MIN_START;
            r_max       <= rcs_pkg::MAX_START;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    rcs_pkg::CFG_NODATA:    r_nodata    <= i_cfg_data;
                    rcs_pkg::CFG_AUTOSCALE: r_autoscale <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end

            // new image
            if (accept && i_in_item.cmd == rcs_pkg::CMD_START) begin
                r_count <= '0;
                r_min   <= rcs_pkg::MIN_START;
                r_max   <= rcs_pkg::MAX_START;
            end

            // load: count every stored beat, min/max only real samples
            if (mem_we) begin
                r_count <= r_count + 1'b1;
                if (!smp_nd) begin
                    if (i_in_item.sample < r_min) begin
                        r_min <= i_in_item.sample;
                    end
                    if (i_in_item.sample > r_max) begin
                        r_max <= i_in_item.sample;
                    end
                end
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // read datapath
    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_inr <= idx_in;
        end
        if (r_state == rcs_pkg::S_READ) begin
            r_diff  <= DW'(rdata) - DW'(r_min);
            r_range <= DW'(r_max) - DW'(r_min);
            r_res.in_range <= r_inr;
            r_res.alpha    <= (r_inr && !rd_nd) ? rcs_pkg::ALPHA_OPAQUE
                                                : rcs_pkg::ALPHA_CLEAR;
            r_res.grey     <= (r_inr && !rd_nd && !r_autoscale) ? trunc_grey : '0;
        end
        if (r_state == rcs_pkg::S_DIV && div_done) begin
            r_res.grey <= div_grey;
        end
        if (out_load) begin
            r_out_item <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

// ----- rtl/rcs_store.sv -----
`default_nettype none

module rcs_store #(
    parameter int DEPTH = rcs_pkg::MAX_SAMPLES,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_we,
    input  wire logic [AW-1:0]                      i_waddr,
    input  wire logic signed [rcs_pkg::SAMPLE_W-1:0] i_wdata,
    input  wire logic                               i_re,
    input  wire logic [AW-1:0]                      i_raddr,
    output logic signed [rcs_pkg::SAMPLE_W-1:0]      o_rdata
);

    logic signed [rcs_pkg::SAMPLE_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/rcs_div.sv -----
`default_nettype none

module rcs_div (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_start,
    input  wire logic signed [rcs_pkg::NUM_W-1:0]    i_num,
    input  wire logic signed [rcs_pkg::DEN_W-1:0]    i_den,
    output logic                                    o_done,
    output logic [rcs_pkg::GREY_W-1:0]              o_grey
);

    localparam int NW   = rcs_pkg::NUM_W;
    localparam int DW   = rcs_pkg::DEN_W;
    localparam int CNTW = $clog2(NW + 1);

    logic            r_busy;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    logic [NW-1:0]   r_dvd;
    logic [DW-1:0]   r_rem;
    logic [DW-1:0]   r_dmag;
    logic            r_neg;

    logic [NW-1:0]   num_mag;
    logic [DW-1:0]   den_mag;
    logic [DW:0]     shifted;
    logic [DW+1:0]   trial;
    logic            fits;
    logic [rcs_pkg::GREY_W-1:0] q_lo;
    logic            rem_nz;

    assign num_mag = i_num[NW-1] ? NW'(-i_num) : NW'(i_num);
    assign den_mag = i_den[DW-1] ? DW'(-i_den) : DW'(i_den);

    // one restoring step per cycle, msb first
    assign shifted = {r_rem, r_dvd[NW-1]};
    assign trial   = {1'b0, shifted} - {2'b00, r_dmag};
    assign fits    = ~trial[DW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd  <= num_mag;
            r_rem  <= '0;
            r_dmag <= den_mag;
            r_neg  <= i_num[NW-1] ^ i_den[DW-1];
        end else if (r_busy) begin
            r_dvd <= {r_dvd[NW-2:0], fits};
            r_rem <= fits ? trial[DW-1:0] : shifted[DW-1:0];
        end
    end

    // floor for mixed signs: -q, or -q-1 when inexact
    assign q_lo   = r_dvd[rcs_pkg::GREY_W-1:0];
    assign rem_nz = (r_rem != '0);

    always_comb begin
        if (!r_neg) begin
            o_grey = q_lo;
        end else if (rem_nz) begin
            o_grey = ~q_lo;
        end else begin
            o_grey = -q_lo;
        end
    end

    assign o_done = r_done;

endmodule

`default_nettype wire
